// File: rtl/bps_pkg.sv
// Shared types and constants for the buzzer pattern sequencer.
package bps_pkg;

    // Command codes carried in the input tuser
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_STOP   = 3'd1;
    localparam logic [2:0] OP_SINGLE = 3'd2;
    localparam logic [2:0] OP_DOUBLE = 3'd3;
    localparam logic [2:0] OP_ALARM  = 3'd4;

    // Fixed alarm cadence, in ms
    localparam logic [15:0] ALARM_ON1_MS  = 16'd150;
    localparam logic [15:0] ALARM_OFF1_MS = 16'd100;
    localparam logic [15:0] ALARM_ON2_MS  = 16'd180;
    localparam logic [15:0] ALARM_OFF2_MS = 16'd800;

    // Step counts of the built-in patterns
    localparam logic [2:0] SINGLE_STEPS = 3'd1;
    localparam logic [2:0] DOUBLE_STEPS = 3'd3;
    localparam logic [2:0] ALARM_STEPS  = 3'd4;

    // One command as held in the input register
    typedef struct packed {
        logic [15:0] gap_ms;
        logic [15:0] tone_ms;
        logic [31:0] now_ms;
        logic [2:0]  operation;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [1:0] step_index;
        logic       pattern_active;
        logic       buzzer_on;
    } t_result;

endpackage

// File: rtl/bps_step_table.sv
// Step table: length and level of each pattern step, loaded by beep commands.
module bps_step_table #(
    parameter int STEP_SLOTS = 4,
    parameter int IW         = $clog2(STEP_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_exec,
    input  bps_pkg::t_cmd i_cmd,
    input  logic [IW-1:0] i_len_idx,
    input  logic [IW-1:0] i_lvl_idx,
    output logic [15:0]   o_len,
    output logic          o_lvl,
    output logic          o_lvl0
);

    logic [15:0] r_len [STEP_SLOTS];
    logic        r_lvl [STEP_SLOTS];

    // Load the steps a command uses; the rest keep their contents
    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            unique case (i_cmd.operation)
                bps_pkg::OP_SINGLE: begin
                    r_len[0] <= i_cmd.tone_ms;
                    r_lvl[0] <= 1'b1;
                end
                bps_pkg::OP_DOUBLE: begin
                    r_len[0] <= i_cmd.tone_ms;
                    r_lvl[0] <= 1'b1;
                    r_len[1] <= i_cmd.gap_ms;
                    r_lvl[1] <= 1'b0;
                    r_len[2] <= i_cmd.tone_ms;
                    r_lvl[2] <= 1'b1;
                end
                bps_pkg::OP_ALARM: begin
                    r_len[0] <= bps_pkg::ALARM_ON1_MS;
                    r_lvl[0] <= 1'b1;
                    r_len[1] <= bps_pkg::ALARM_OFF1_MS;
                    r_lvl[1] <= 1'b0;
                    r_len[2] <= bps_pkg::ALARM_ON2_MS;
                    r_lvl[2] <= 1'b1;
                    r_len[3] <= bps_pkg::ALARM_OFF2_MS;
                    r_lvl[3] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Reads for the current step length, the following step level and the step-zero level
    assign o_len  = r_len[i_len_idx];
    assign o_lvl  = r_lvl[i_lvl_idx];
    assign o_lvl0 = r_lvl[0];

endmodule

// File: rtl/bps_step_ctrl.sv
// Pattern state and the per-command step rule.
module bps_step_ctrl #(
    parameter int STEP_SLOTS = 4,
    parameter int IW         = $clog2(STEP_SLOTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_exec,
    input  bps_pkg::t_cmd    i_cmd,
    input  logic [15:0]      i_len,
    input  logic             i_lvl,
    input  logic             i_lvl0,
    output logic [IW-1:0]    o_len_idx,
    output logic [IW-1:0]    o_lvl_idx,
    output bps_pkg::t_result o_result
);

    logic [2:0]  r_total, n_total;
    logic [2:0]  r_now, n_now;
    logic        r_rep, n_rep;
    logic [31:0] r_start, n_start;
    logic        r_drive, n_drive;

    logic [2:0]  nxt;
    logic [31:0] elapsed;

    assign nxt       = r_now + 3'd1;
    assign elapsed   = i_cmd.now_ms - r_start;
    assign o_len_idx = IW'(r_now);
    assign o_lvl_idx = IW'(nxt);

    // Step rule
    always_comb begin
        n_total = r_total;
        n_now   = r_now;
        n_rep   = r_rep;
        n_start = r_start;
        n_drive = r_drive;
        unique case (i_cmd.operation) inside
            bps_pkg::OP_TICK: begin
                if (r_total != 3'd0 && elapsed >= {16'd0, i_len}) begin
                    if (nxt >= r_total) begin
                        if (r_rep) begin
                            n_now   = 3'd0;
                            n_start = i_cmd.now_ms;
                            n_drive = i_lvl0;
                        end else begin
                            n_total = 3'd0;
                            n_now   = 3'd0;
                            n_rep   = 1'b0;
                            n_drive = 1'b0;
                        end
                    end else begin
                        n_now   = nxt;
                        n_start = i_cmd.now_ms;
                        n_drive = i_lvl;
                    end
                end
            end
            bps_pkg::OP_STOP: begin
                n_total = 3'd0;
                n_now   = 3'd0;
                n_rep   = 1'b0;
                n_drive = 1'b0;
            end
            bps_pkg::OP_SINGLE, bps_pkg::OP_DOUBLE, bps_pkg::OP_ALARM: begin
                n_now   = 3'd0;
                n_start = i_cmd.now_ms;
                n_drive = 1'b1;
                n_rep   = (i_cmd.operation == bps_pkg::OP_ALARM);
                if (i_cmd.operation == bps_pkg::OP_SINGLE) begin
                    n_total = bps_pkg::SINGLE_STEPS;
                end else if (i_cmd.operation == bps_pkg::OP_DOUBLE) begin
                    n_total = bps_pkg::DOUBLE_STEPS;
                end else begin
                    n_total = bps_pkg::ALARM_STEPS;
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated once per executed command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 3'd0;
            r_now   <= 3'd0;
            r_rep   <= 1'b0;
            r_start <= 32'd0;
            r_drive <= 1'b0;
        end else if (i_exec) begin
            r_total <= n_total;
            r_now   <= n_now;
            r_rep   <= n_rep;
            r_start <= n_start;
            r_drive <= n_drive;
        end
    end

    // Result reflects the state after this command
    assign o_result.buzzer_on      = n_drive;
    assign o_result.pattern_active = (n_total != 3'd0);
    assign o_result.step_index     = n_now[1:0];

endmodule

// File: rtl/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer top level: stream ports, input and result registers.
// Each command (tick, stop, single beep, double beep, repeating alarm) on the
// slave stream yields one result on the master stream: buzzer level, pattern
// active flag and current step index. An accepted command is held in the input
// register and executed into the result register when that is free or being
// drained; a new command can be taken every cycle while the master stream takes
// results. While a result waits, the block holds one further command in the
// input register before s_axis_tready drops. The step rule (elapsed-time
// subtract, length compare, index update) is the only logic between the two
// registers. Time arithmetic is modulo 2^32 ms.
module buzzer_pattern_sequencer #(
    parameter int STEP_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // now_ms[31:0], tone_ms[47:32], gap_ms[63:48]
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // buzzer_on[0], pattern_active[1], step_index[3:2]
);

    localparam int IW = $clog2(STEP_SLOTS);

    logic             r_in_valid;
    bps_pkg::t_cmd    r_cmd;
    logic             r_out_valid;
    bps_pkg::t_result r_out;
    bps_pkg::t_result result;
    logic             exec;
    logic [IW-1:0]    len_idx;
    logic [IW-1:0]    lvl_idx;
    logic [15:0]      len;
    logic             lvl;
    logic             lvl0;

    // Command moves on when the result register is free or being drained
    assign exec          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || exec;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd.operation <= s_axis_tuser;
            r_cmd.now_ms    <= s_axis_tdata[31:0];
            r_cmd.tone_ms   <= s_axis_tdata[47:32];
            r_cmd.gap_ms    <= s_axis_tdata[63:48];
        end
    end

    bps_step_table #(
        .STEP_SLOTS(STEP_SLOTS),
        .IW        (IW)
    ) u_table (
        .i_clk    (i_clk),
        .i_exec   (exec),
        .i_cmd    (r_cmd),
        .i_len_idx(len_idx),
        .i_lvl_idx(lvl_idx),
        .o_len    (len),
        .o_lvl    (lvl),
        .o_lvl0   (lvl0)
    );

    bps_step_ctrl #(
        .STEP_SLOTS(STEP_SLOTS),
        .IW        (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (exec),
        .i_cmd    (r_cmd),
        .i_len    (len),
        .i_lvl    (lvl),
        .i_lvl0   (lvl0),
        .o_len_idx(len_idx),
        .o_lvl_idx(lvl_idx),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

`ifndef SYNTHESIS
    // An executed command always leaves a result behind
    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_out_valid)
        else $error("executed command left no result");

    // Input side stalls only when both registers are full and output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without cause");

    // An idle sequencer reports silence at step zero
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |->
            (m_axis_tdata[0] == 1'b0 && m_axis_tdata[3:2] == 2'd0))
        else $error("idle result not silent at step zero");
`endif

endmodule
